FILE: hw/rtl/haptic_sphere_contact_force_defines.svh
// Assertion macros for the haptic sphere contact force block.
`ifndef HAPTIC_SPHERE_CONTACT_FORCE_DEFINES_SVH
`define HAPTIC_SPHERE_CONTACT_FORCE_DEFINES_SVH
`ifndef SYNTHESIS
`define HSCF_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("assertion failed");
`define HSCF_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define HSCF_ASSERT_IMP(label, clk, rst, a, c)
`define HSCF_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

FILE: hw/rtl/hscf_pkg.sv
package hscf_pkg;
  localparam int POS_WIDTH_DEF = 20;
  localparam int FRAC_BITS_DEF = 10;
  localparam int FORCE_WIDTH = 17;
  localparam int RAD_WIDTH = 18;
  localparam int CUR_WIDTH = 16;
  localparam int STIFF_WIDTH = 21;
  localparam int LIM_WIDTH = 16;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_CENTRE_X = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CENTRE_Y = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CENTRE_Z = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SPHERE_RADIUS = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_CURSOR_RADIUS = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_STIFFNESS = 3'd5;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_FORCE_LIMIT = 3'd6;

  typedef struct packed {
    logic load;
    logic sq_start;
    logic sq_acc;
    logic sqrt_init;
    logic sqrt_step;
    logic eval;
    logic mag_mul;
    logic div_init;
    logic div_step;
    logic div_store;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic contact;
  } stat_t;
endpackage

FILE: hw/rtl/hscf_ctrl.sv
module hscf_ctrl #(
  parameter int SQRT_STEPS = 33,
  parameter int DIV_STEPS = 17
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_busy,
  output hscf_pkg::cmd_t cmd,
  input  hscf_pkg::stat_t stat
);
  import hscf_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_SQ   = 10'b0000000010,
    S_SQRT = 10'b0000000100,
    S_EVAL = 10'b0000001000,
    S_MAG  = 10'b0000010000,
    S_DIVI = 10'b0000100000,
    S_DIV  = 10'b0001000000,
    S_DST  = 10'b0010000000,
    S_OUT  = 10'b0100000000,
    S_WAIT = 10'b1000000000
  } state_t;

  localparam int CW = $clog2(SQRT_STEPS + DIV_STEPS + 4);

  state_t state, state_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [1:0] lane, lane_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    lane_next = lane;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SQ;
          cnt_next = '0;
        end
      end
      S_SQ: begin
        if (cnt == '0) cmd.sq_start = 1'b1;
        else cmd.sq_acc = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(2)) begin
          state_next = S_SQRT;
          cnt_next = '0;
        end
      end
      S_SQRT: begin
        if (cnt == '0) cmd.sqrt_init = 1'b1;
        else cmd.sqrt_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(SQRT_STEPS)) state_next = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        state_next = S_MAG;
      end
      S_MAG: begin
        cmd.mag_mul = 1'b1;
        lane_next = '0;
        state_next = stat.contact ? S_DIVI : S_WAIT;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == CW'(DIV_STEPS - 1)) state_next = S_DST;
      end
      S_DST: begin
        cmd.div_store = 1'b1;
        lane_next = lane + 1'b1;
        state_next = (lane == 2'd2) ? S_WAIT : S_DIVI;
      end
      S_WAIT: begin
        if (!out_busy) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      lane <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
      lane <= lane_next;
    end
  end
endmodule

FILE: hw/rtl/hscf_dp.sv
module hscf_dp #(
  parameter int POS_WIDTH = hscf_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS = hscf_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  hscf_pkg::cmd_t cmd,
  output hscf_pkg::stat_t stat,
  input  logic cfg_valid,
  input  logic [hscf_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [hscf_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic just_activated,
  input  logic out_ready,
  output logic out_valid,
  output logic signed [hscf_pkg::FORCE_WIDTH-1:0] force_x,
  output logic signed [hscf_pkg::FORCE_WIDTH-1:0] force_y,
  output logic signed [hscf_pkg::FORCE_WIDTH-1:0] force_z,
  output logic inside_mode,
  output logic in_contact
);
  import hscf_pkg::*;

  localparam int DW = POS_WIDTH + 1;
  localparam int AW = POS_WIDTH + 1;
  localparam int SW = 2 * AW + 2;
  localparam int RW = SW / 2 + 1;
  localparam int EW = RW + 2;
  localparam int PW = STIFF_WIDTH + EW;
  localparam int QW = LIM_WIDTH + AW;

  logic signed [POS_WIDTH-1:0] centre_x, centre_y, centre_z;
  logic [RAD_WIDTH-1:0] sphere_radius;
  logic [CUR_WIDTH-1:0] cursor_radius;
  logic signed [STIFF_WIDTH-1:0] stiffness;
  logic [LIM_WIDTH-1:0] force_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      centre_x <= '0;
      centre_y <= '0;
      centre_z <= -POS_WIDTH'(10 << FRAC_BITS);
      sphere_radius <= RAD_WIDTH'(7 << FRAC_BITS);
      cursor_radius <= CUR_WIDTH'(1 << (FRAC_BITS - 1));
      stiffness <= -STIFF_WIDTH'(40 << FRAC_BITS);
      force_limit <= LIM_WIDTH'(40 << FRAC_BITS);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTRE_X: centre_x <= cfg_data[POS_WIDTH-1:0];
        REG_CENTRE_Y: centre_y <= cfg_data[POS_WIDTH-1:0];
        REG_CENTRE_Z: centre_z <= cfg_data[POS_WIDTH-1:0];
        REG_SPHERE_RADIUS: sphere_radius <= cfg_data[RAD_WIDTH-1:0];
        REG_CURSOR_RADIUS: cursor_radius <= cfg_data[CUR_WIDTH-1:0];
        REG_STIFFNESS: stiffness <= cfg_data[STIFF_WIDTH-1:0];
        REG_FORCE_LIMIT: force_limit <= cfg_data[LIM_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  logic [AW-1:0] ax [3];
  logic neg [3];
  logic act;
  logic [SW-1:0] sum;
  logic [1:0] sq_sel;
  logic [AW-1:0] sq_op;
  logic [SW-1:0] rem;
  logic [SW-1:0] root;
  logic [SW-1:0] bitv;
  logic inside_latch;
  logic signed [EW-1:0] e;
  logic contact;
  logic neg_ke;
  logic [LIM_WIDTH-1:0] mag;
  logic [1:0] lane;
  logic [QW-1:0] dnum;
  logic [RW:0] drem;
  logic [QW-1:0] quo;
  logic [FORCE_WIDTH-1:0] fq [3];

  logic signed [DW-1:0] dx, dy, dz;
  assign dx = DW'(pos_x) - DW'(centre_x);
  assign dy = DW'(pos_y) - DW'(centre_y);
  assign dz = DW'(pos_z) - DW'(centre_z);

  assign sq_op = ax[sq_sel];

  logic [SW-1:0] trial;
  assign trial = root + bitv;

  logic signed [EW-1:0] rad_in, rad_out, dsig;
  assign dsig = EW'(root);
  assign rad_in = EW'(sphere_radius) - EW'(cursor_radius);
  assign rad_out = EW'(sphere_radius) + EW'(cursor_radius);

  logic signed [EW-1:0] e_now;
  logic lat_now;
  assign lat_now = act ? (dsig < EW'(sphere_radius)) : inside_latch;
  assign e_now = dsig - (lat_now ? rad_in : rad_out);

  logic [EW-1:0] abs_e;
  logic [STIFF_WIDTH-1:0] abs_k;
  logic [PW-1:0] prod;
  logic [PW-1:0] prod_sh;
  assign abs_e = e[EW-1] ? -e : e;
  assign abs_k = stiffness[STIFF_WIDTH-1] ? -stiffness : stiffness;
  assign prod = PW'(abs_e) * PW'(abs_k);
  assign prod_sh = prod >> FRAC_BITS;

  logic [RW+1:0] dtry;
  assign dtry = {drem, dnum[QW-1]} - (RW+2)'(root);

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_latch <= 1'b0;
    end else if (cmd.eval && act) begin
      inside_latch <= lat_now;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ax[0] <= dx[DW-1] ? AW'(-dx) : AW'(dx);
      ax[1] <= dy[DW-1] ? AW'(-dy) : AW'(dy);
      ax[2] <= dz[DW-1] ? AW'(-dz) : AW'(dz);
      neg[0] <= dx[DW-1];
      neg[1] <= dy[DW-1];
      neg[2] <= dz[DW-1];
      act <= just_activated;
      sq_sel <= '0;
    end
    if (cmd.sq_start || cmd.sq_acc) begin
      sum <= (cmd.sq_start ? '0 : sum) + SW'(SW'(sq_op) * SW'(sq_op));
      sq_sel <= sq_sel + 1'b1;
    end
    if (cmd.sqrt_init) begin
      rem <= sum;
      root <= '0;
      bitv <= SW'(1) << (2 * (SW / 2) - 2);
    end
    if (cmd.sqrt_step) begin
      if (rem >= trial) begin
        rem <= rem - trial;
        root <= (root >> 1) + bitv;
      end else begin
        root <= root >> 1;
      end
      bitv <= bitv >> 2;
    end
    if (cmd.eval) begin
      e <= e_now;
      contact <= (lat_now ? (e_now > 0) : (e_now < 0)) && (root != '0);
    end
    if (cmd.mag_mul) begin
      neg_ke <= stiffness[STIFF_WIDTH-1] != e[EW-1];
      mag <= (prod_sh > PW'(force_limit)) ? force_limit : LIM_WIDTH'(prod_sh);
      lane <= '0;
      fq[0] <= '0;
      fq[1] <= '0;
      fq[2] <= '0;
    end
    if (cmd.div_init) begin
      dnum <= QW'(mag) * QW'(ax[lane]);
      drem <= '0;
      quo <= '0;
    end
    if (cmd.div_step) begin
      if (!dtry[RW+1]) begin
        drem <= dtry[RW:0];
        quo <= {quo[QW-2:0], 1'b1};
      end else begin
        drem <= {drem[RW-1:0], dnum[QW-1]};
        quo <= {quo[QW-2:0], 1'b0};
      end
      dnum <= dnum << 1;
    end
    if (cmd.div_store) begin
      fq[lane] <= (neg_ke != neg[lane]) ? -FORCE_WIDTH'(quo) : FORCE_WIDTH'(quo);
      lane <= lane + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      force_x <= fq[0];
      force_y <= fq[1];
      force_z <= fq[2];
      inside_mode <= inside_latch;
      in_contact <= contact;
    end
  end

  assign stat.contact = contact;
endmodule

FILE: hw/rtl/haptic_sphere_contact_force.sv
// Haptic sphere contact force: penalty-spring force against a fixed sphere.
// A tool position transfers in on the input channel (in_valid, in_ready).
// The block forms the offset from the sphere centre, its length by a
// bit-serial square root, the spring magnitude by one multiply, and each
// force component by a restoring divider working one quotient bit a cycle.
// One result transfers out per input on the output channel.
// The steps in order are the squaring of the three offsets, the square
// root loop and, with contact only, three serial divisions. A new item
// can be accepted in the same cycle that out_valid rises.
// One item is processed at a time; in_ready is high only while idle.
// The result sits in an output register; while the receiver stalls the
// block holds it, and a further item is accepted but waits to load its result.
// Reset clears the inside latch and loads the default sphere registers.
// Configuration writes transfer on cfg_valid and cfg_ready, which is always
// high; they must only be issued while the block is idle.
module haptic_sphere_contact_force #(
  parameter int POS_WIDTH = hscf_pkg::POS_WIDTH_DEF,
  parameter int FRAC_BITS = hscf_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [hscf_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
  input  logic [hscf_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [POS_WIDTH-1:0] pos_x,
  input  logic signed [POS_WIDTH-1:0] pos_y,
  input  logic signed [POS_WIDTH-1:0] pos_z,
  input  logic just_activated,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [hscf_pkg::FORCE_WIDTH-1:0] force_x,
  output logic signed [hscf_pkg::FORCE_WIDTH-1:0] force_y,
  output logic signed [hscf_pkg::FORCE_WIDTH-1:0] force_z,
  output logic inside_mode,
  output logic in_contact
);
  import hscf_pkg::*;
`include "haptic_sphere_contact_force_defines.svh"

  localparam int SW = 2 * (POS_WIDTH + 1) + 2;
  localparam int SQRT_STEPS = SW / 2;
  localparam int DIV_STEPS = LIM_WIDTH + POS_WIDTH + 1;

  cmd_t cmd;
  stat_t stat;
  logic out_busy;

  assign cfg_ready = 1'b1;
  assign out_busy = out_valid && !out_ready;

  hscf_ctrl #(.SQRT_STEPS(SQRT_STEPS), .DIV_STEPS(DIV_STEPS)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_busy(out_busy), .cmd(cmd), .stat(stat)
  );

  hscf_dp #(.POS_WIDTH(POS_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .just_activated(just_activated), .out_ready(out_ready),
    .out_valid(out_valid), .force_x(force_x), .force_y(force_y),
    .force_z(force_z), .inside_mode(inside_mode), .in_contact(in_contact)
  );

  `HSCF_ASSERT_NXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `HSCF_ASSERT_IMP(a_no_accept_pending, clk, rst, out_valid && !out_ready, !cmd.out_load)
  `HSCF_ASSERT_IMP(a_zero_without_contact, clk, rst, out_valid && !in_contact,
    force_x == '0 && force_y == '0 && force_z == '0)
endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import hscf_pkg::*;

  localparam int PW = POS_WIDTH_DEF;
  localparam int FB = FRAC_BITS_DEF;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [PW-1:0] px;
    logic signed [PW-1:0] py;
    logic signed [PW-1:0] pz;
    logic act;
  } pos_item_t;

  typedef struct packed {
    logic signed [FORCE_WIDTH-1:0] fx;
    logic signed [FORCE_WIDTH-1:0] fy;
    logic signed [FORCE_WIDTH-1:0] fz;
    logic mode_flag;
    logic contact;
  } force_item_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_ready;
  logic signed [PW-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
  logic just_activated = 0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [FORCE_WIDTH-1:0] force_x, force_y, force_z;
  logic inside_mode, in_contact;

  haptic_sphere_contact_force dut (.*);

  always #5 clk = ~clk;

  pos_item_t pending_pos[$];
  force_item_t expected_force[$];
  int errors = 0;
  int idle_cycles = 0;
  bit calm = 0;
  int hold_off = 0;

  // Sphere model state
  longint m_cx, m_cy, m_cz, m_rad, m_cur, m_stiff, m_lim;
  bit m_inside;

  function automatic longint sext_w(logic [31:0] v, int w);
    longint r;
    r = v & ((64'd1 << w) - 1);
    if (r[w-1]) r = r - (64'sd1 << w);
    return r;
  endfunction

  function automatic longint int_sqrt(longint s);
    longint r, b;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      b = r + (64'sd1 << k);
      if (b * b <= s) r = b;
    end
    return r;
  endfunction

  function automatic force_item_t predict_force(pos_item_t p);
    force_item_t f;
    longint dv[3], sum, d, e, mag, q, a;
    bit contact, neg_ke;
    dv[0] = longint'(p.px) - m_cx;
    dv[1] = longint'(p.py) - m_cy;
    dv[2] = longint'(p.pz) - m_cz;
    sum = 0;
    for (int i = 0; i < 3; i++) sum += dv[i] * dv[i];
    d = int_sqrt(sum);
    if (p.act) m_inside = d < m_rad;
    e = m_inside ? d - (m_rad - m_cur) : d - (m_rad + m_cur);
    contact = (m_inside ? e > 0 : e < 0) && d != 0;
    neg_ke = (m_stiff < 0) != (e < 0);
    mag = 0;
    if (contact) begin
      mag = ((m_stiff < 0 ? -m_stiff : m_stiff) * (e < 0 ? -e : e)) >>> FB;
      if (mag > m_lim) mag = m_lim;
    end
    for (int i = 0; i < 3; i++) begin
      q = 0;
      if (contact) begin
        a = dv[i] < 0 ? -dv[i] : dv[i];
        q = mag * a / d;
        if (neg_ke != (dv[i] < 0)) q = -q;
      end
      if (i == 0) f.fx = q[FORCE_WIDTH-1:0];
      else if (i == 1) f.fy = q[FORCE_WIDTH-1:0];
      else f.fz = q[FORCE_WIDTH-1:0];
    end
    f.mode_flag = m_inside;
    f.contact = contact;
    return f;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // Input driver
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_force.push_back(predict_force(
          pos_item_t'{pos_x, pos_y, pos_z, just_activated}));
        pending_pos.pop_front();
      end
      if ((!in_valid || in_ready) && pending_pos.size() > 0 &&
          (calm || $urandom_range(99) >= 17)) begin
        pos_item_t n;
        n = pending_pos[0];
        in_valid <= 1;
        pos_x <= n.px; pos_y <= n.py; pos_z <= n.pz; just_activated <= n.act;
      end else if (in_valid && in_ready) in_valid <= 0;
    end
  end

  // Result monitor and receiver stalls
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_force.size() == 0) begin
          $display("unexpected result transfer");
          errors++;
        end else begin
          force_item_t w;
          w = expected_force.pop_front();
          if (force_x !== w.fx) report_mismatch("force_x", force_x, w.fx);
          if (force_y !== w.fy) report_mismatch("force_y", force_y, w.fy);
          if (force_z !== w.fz) report_mismatch("force_z", force_z, w.fz);
          if (inside_mode !== w.mode_flag)
            report_mismatch("inside_mode", inside_mode, w.mode_flag);
          if (in_contact !== w.contact) report_mismatch("in_contact", in_contact, w.contact);
        end
      end
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ready <= 0;
      end else out_ready <= calm || $urandom_range(99) >= 17;
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, longint val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val[31:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    case (idx)
      REG_CENTRE_X: m_cx = sext_w(val[31:0], PW);
      REG_CENTRE_Y: m_cy = sext_w(val[31:0], PW);
      REG_CENTRE_Z: m_cz = sext_w(val[31:0], PW);
      REG_SPHERE_RADIUS: m_rad = val & ((1 << RAD_WIDTH) - 1);
      REG_CURSOR_RADIUS: m_cur = val & ((1 << CUR_WIDTH) - 1);
      REG_STIFFNESS: m_stiff = sext_w(val[31:0], STIFF_WIDTH);
      REG_FORCE_LIMIT: m_lim = val & ((1 << LIM_WIDTH) - 1);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_pos.size() > 0 || expected_force.size() > 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic logic signed [PW-1:0] rand_pos(longint c, longint r);
    longint v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = c + longint'($urandom_range(2 * r + 8)) - r - 4;
      default: v = c + ($urandom_range(1) ? r : -r) + longint'($urandom_range(600)) - 300;
    endcase
    return v[PW-1:0];
  endfunction

  // Points near the sphere surface, offset mainly along x, give contact often.
  task automatic queue_random(int n, longint c0, longint c1, longint c2, longint r);
    for (int k = 0; k < n; k++) begin
      pos_item_t p;
      p.px = rand_pos(c0, r);
      p.py = rand_pos(c1, $urandom_range(3) == 0 ? r : 0);
      p.pz = rand_pos(c2, $urandom_range(3) == 0 ? r : 0);
      p.act = $urandom_range(9) == 0;
      pending_pos.push_back(p);
    end
  endtask

  localparam logic signed [PW-1:0] PMAX = {1'b0, {(PW-1){1'b1}}};
  localparam logic signed [PW-1:0] PMIN = {1'b1, {(PW-1){1'b0}}};

  initial begin
    m_cx = 0; m_cy = 0; m_cz = -10240; m_rad = 7168; m_cur = 512;
    m_stiff = -40960; m_lim = 40960; m_inside = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Reset configuration: zero distance, inside, outside, extremes.
    pending_pos.push_back('{0, 0, -10240, 1});
    pending_pos.push_back('{0, 0, -10240, 0});
    pending_pos.push_back('{100, 0, -10240 + 7000, 1});
    pending_pos.push_back('{0, 0, -10240 + 6800, 0});
    pending_pos.push_back('{0, 0, -10240 + 7400, 1});
    pending_pos.push_back('{0, -7500, -10240, 0});
    pending_pos.push_back('{PMAX, PMAX, PMAX, 1});
    pending_pos.push_back('{PMIN, PMIN, PMIN, 0});
    pending_pos.push_back('{PMIN, PMAX, 0, 1});
    pending_pos.push_back('{-1, -1, -1, 0});
    pending_pos.push_back('{3000, -3000, -10240 + 5000, 0});
    wait_drained();

    // Extreme registers; cursor wider than the sphere.
    write_reg(REG_CENTRE_X, 32'hFFF8_0000);
    write_reg(REG_CENTRE_Y, 524287);
    write_reg(REG_CENTRE_Z, 0);
    write_reg(REG_SPHERE_RADIUS, 100);
    write_reg(REG_CURSOR_RADIUS, 65535);
    write_reg(REG_STIFFNESS, 1048575);
    write_reg(REG_FORCE_LIMIT, 65535);
    write_reg(3'd7, 32'hFFFF_FFFF);
    pending_pos.push_back('{PMIN, PMAX, 0, 1});
    pending_pos.push_back('{PMIN + 50, PMAX, 0, 0});
    pending_pos.push_back('{0, 0, 0, 1});
    pending_pos.push_back('{PMAX, PMIN, PMAX, 0});
    wait_drained();

    // Zero stiffness, zero limit.
    write_reg(REG_STIFFNESS, 0);
    write_reg(REG_FORCE_LIMIT, 0);
    write_reg(REG_SPHERE_RADIUS, 262143);
    pending_pos.push_back('{PMIN + 10, PMAX, 0, 1});
    pending_pos.push_back('{0, 0, 0, 0});
    wait_drained();

    // Long receiver hold-off while inputs keep coming.
    hold_off = 400;
    calm = 1;
    write_reg(REG_CENTRE_X, 0);
    write_reg(REG_CENTRE_Y, 0);
    write_reg(REG_CENTRE_Z, -10240);
    write_reg(REG_SPHERE_RADIUS, 7168);
    write_reg(REG_CURSOR_RADIUS, 512);
    write_reg(REG_STIFFNESS, 32'hFFFF_6000);
    write_reg(REG_FORCE_LIMIT, 40960);
    queue_random(200, 0, 0, -10240, 7168);
    wait_drained();
    calm = 0;

    for (int ph = 0; ph < 6; ph++) begin
      longint c0, c1, c2, r;
      c0 = longint'($urandom_range(200000)) - 100000;
      c1 = longint'($urandom_range(200000)) - 100000;
      c2 = longint'($urandom_range(200000)) - 100000;
      r = $urandom_range(ph == 0 ? 20 : 60000);
      write_reg(REG_CENTRE_X, c0);
      write_reg(REG_CENTRE_Y, c1);
      write_reg(REG_CENTRE_Z, c2);
      write_reg(REG_SPHERE_RADIUS, r);
      write_reg(REG_CURSOR_RADIUS, $urandom_range(ph == 5 ? 65535 : 4000));
      write_reg(REG_STIFFNESS, $urandom);
      write_reg(REG_FORCE_LIMIT, $urandom);
      queue_random(250, c0, c1, c2, r + m_cur);
      wait_drained();
    end

    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end
endmodule
